// ===== design/cancfb_pkg.sv =====
// Shared types, constants and the CRC8 byte step for the control frame builder.
package cancfb_pkg;

    localparam logic [7:0]  CRC_POLY  = 8'h1D;
    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [7:0]  CRC_TOP   = 8'h80;
    localparam logic [10:0] FRAME_ID  = 11'h101;
    localparam logic [3:0]  FRAME_LEN = 4'd8;

    // One command beat with its alive counter attached.
    typedef struct packed {
        logic [7:0] counter;
        logic [7:0] steer;
        logic [7:0] torque;
        logic [1:0] flags;
    } t_cmd;

    // MSB-first CRC8 update over one data byte.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((v & CRC_TOP) != 8'h00) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== design/cancfb_crc.sv =====
// CRC8 over data bytes 1 to 7 of the control frame.
module cancfb_crc (
    input  cancfb_pkg::t_cmd i_cmd,
    output logic [7:0]       o_crc
);

    logic [7:0] c1, c2, c3, c4, c5, c6;

    // bytes 4..6 are the zero reserved bytes
    always_comb begin
        c1    = cancfb_pkg::crc_byte(cancfb_pkg::CRC_INIT, i_cmd.counter);
        c2    = cancfb_pkg::crc_byte(c1, i_cmd.steer);
        c3    = cancfb_pkg::crc_byte(c2, i_cmd.torque);
        c4    = cancfb_pkg::crc_byte(c3, 8'h00);
        c5    = cancfb_pkg::crc_byte(c4, 8'h00);
        c6    = cancfb_pkg::crc_byte(c5, 8'h00);
        o_crc = cancfb_pkg::crc_byte(c6, {6'd0, i_cmd.flags});
    end

endmodule

// ===== design/cancfb_in_stage.sv =====
// Input register stage: captures a command beat and stamps the alive counter.
module cancfb_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [7:0]       i_steer_request,
    input  logic signed [7:0]       i_torque_request,
    input  logic                    i_steer_auto,
    input  logic                    i_torque_auto,
    input  logic                    i_advance,
    output logic                    o_stall,
    output logic                    o_valid,
    output cancfb_pkg::t_cmd        o_cmd
);

    logic             r_valid;
    logic [7:0]       r_alive;
    cancfb_pkg::t_cmd r_cmd;
    logic             accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_alive <= 8'd0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_alive <= r_alive + 8'd1;
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.counter <= r_alive;
            r_cmd.steer   <= i_steer_request;
            r_cmd.torque  <= i_torque_request;
            r_cmd.flags   <= {i_torque_auto, i_steer_auto};
        end
    end

endmodule

// ===== design/can_control_frame_builder.sv =====
// Top level: input register, CRC8 logic and frame output register.
// Builds one 8-byte control frame (id 0x101, length 8) per command beat. A command passes
// through the input register, where it is stamped with the alive counter, and then through
// the CRC8 network into the output register. The block takes one beat per cycle as long as
// the output side is not stalled; the alive counter starts at zero after reset and advances
// once per accepted beat, wrapping from 255 to 0.
module can_control_frame_builder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [7:0]  i_steer_request,
    input  logic signed [7:0]  i_torque_request,
    input  logic               i_steer_auto,
    input  logic               i_torque_auto,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [10:0]        o_frame_id,
    output logic [3:0]         o_frame_length,
    output logic [7:0]         o_check_byte,
    output logic [7:0]         o_counter_byte,
    output logic [7:0]         o_steer_byte,
    output logic [7:0]         o_torque_byte,
    output logic [1:0]         o_flags_byte
);

    logic             s1_valid;
    cancfb_pkg::t_cmd s1_cmd;
    logic [7:0]       crc;
    logic             advance;
    logic             r_valid;
    cancfb_pkg::t_cmd r_cmd;
    logic [7:0]       r_crc;

    // output slot frees up when empty or when its beat is taken
    assign advance = !r_valid || !i_stall;

    cancfb_in_stage u_in (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_steer_request  (i_steer_request),
        .i_torque_request (i_torque_request),
        .i_steer_auto     (i_steer_auto),
        .i_torque_auto    (i_torque_auto),
        .i_advance        (advance),
        .o_stall          (o_stall),
        .o_valid          (s1_valid),
        .o_cmd            (s1_cmd)
    );

    cancfb_crc u_crc (
        .i_cmd (s1_cmd),
        .o_crc (crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && s1_valid) begin
            r_cmd <= s1_cmd;
            r_crc <= crc;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_id     = cancfb_pkg::FRAME_ID;
    assign o_frame_length = cancfb_pkg::FRAME_LEN;
    assign o_check_byte   = r_crc;
    assign o_counter_byte = r_cmd.counter;
    assign o_steer_byte   = r_cmd.steer;
    assign o_torque_byte  = r_cmd.torque;
    assign o_flags_byte   = r_cmd.flags;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !s1_valid)
        else $error("valid set after reset");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && r_valid && i_stall) |-> o_stall)
        else $error("input taken while both stages full and stalled");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid && $stable(r_crc) && $stable(r_cmd))
        else $error("stalled output beat lost or changed");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && advance) |=> o_valid)
        else $error("input stage beat did not reach output");

endmodule
